[sv/mma_pkg.sv]
// Shared types, constants and the microprogram of the Montgomery arithmetic unit.
// Used by the channel interfaces and by the top level; depends on nothing else.

package mma_pkg;

	// Field widths
	localparam int OP_W      = 2;
	localparam int VAL_W     = 31;
	localparam int MOD_W     = 32;
	localparam int EXP_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = 2 * MOD_W;

	// Default exponent length used by the power sequence
	localparam int EXP_BITS_DEF = 64;

	// Operation codes carried by a request
	typedef enum logic [OP_W-1:0] {
		OP_MUL = 2'd0,
		OP_ENC = 2'd1,
		OP_DEC = 2'd2,
		OP_POW = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODULUS = 2'd0,
		CFG_NEG_INV = 2'd1,
		CFG_R2      = 2'd2,
		CFG_ONE     = 2'd3
	} cfg_idx_t;

	// Datapath action of one microstep
	typedef enum logic [2:0] {
		DP_NOP,
		DP_MULXY,
		DP_MULV,
		DP_MULQ,
		DP_ADD,
		DP_FIN,
		DP_OUTACC
	} dp_op_t;

	typedef enum logic [1:0] {
		X_A,
		X_ACC,
		X_SQ
	} x_sel_t;

	typedef enum logic [1:0] {
		Y_B,
		Y_R2,
		Y_ONE,
		Y_SQ
	} y_sel_t;

	typedef enum logic [1:0] {
		D_ACC,
		D_SQ,
		D_RES
	} dst_t;

	// Sequencing of one microstep
	typedef enum logic [2:0] {
		J_WAIT,
		J_NEXT,
		J_GOTO,
		J_OP,
		J_BIT,
		J_LOOP,
		J_DONE
	} jmp_t;

	localparam int PC_W = 5;

	// Entry points of the microprogram
	localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
	localparam logic [PC_W-1:0] PC_DISP = 5'd1;
	localparam logic [PC_W-1:0] PC_MUL  = 5'd2;
	localparam logic [PC_W-1:0] PC_ENC  = 5'd7;
	localparam logic [PC_W-1:0] PC_DEC  = 5'd12;
	localparam logic [PC_W-1:0] PC_POW  = 5'd17;
	localparam logic [PC_W-1:0] PC_PMUL = 5'd18;
	localparam logic [PC_W-1:0] PC_PSQR = 5'd23;
	localparam logic [PC_W-1:0] PC_POUT = 5'd28;

	typedef struct packed {
		dp_op_t          dp;
		x_sel_t          xs;
		y_sel_t          ys;
		dst_t            dst;
		jmp_t            jmp;
		logic [PC_W-1:0] tgt;
	} ctrl_word_t;

	// Microprogram ROM: every Montgomery product is five steps
	// (x*y, low word times -q^-1, v*q, add and shift, final subtract)
	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t c;
		c = '{dp: DP_NOP, xs: X_A, ys: Y_B, dst: D_RES, jmp: J_NEXT, tgt: PC_IDLE};
		case (pc)
			PC_IDLE: c.jmp = J_WAIT;
			PC_DISP: c.jmp = J_OP;
			PC_MUL: begin
				c.dp = DP_MULXY;
				c.xs = X_A;
				c.ys = Y_B;
			end
			PC_ENC: begin
				c.dp = DP_MULXY;
				c.xs = X_A;
				c.ys = Y_R2;
			end
			PC_DEC: begin
				c.dp = DP_MULXY;
				c.xs = X_A;
				c.ys = Y_ONE;
			end
			PC_POW: begin
				c.jmp = J_BIT;
				c.tgt = PC_PSQR;
			end
			PC_PMUL: begin
				c.dp = DP_MULXY;
				c.xs = X_ACC;
				c.ys = Y_SQ;
			end
			PC_PSQR: begin
				c.dp = DP_MULXY;
				c.xs = X_SQ;
				c.ys = Y_SQ;
			end
			PC_MUL + 5'd1, PC_ENC + 5'd1, PC_DEC + 5'd1, PC_PMUL + 5'd1, PC_PSQR + 5'd1:
				c.dp = DP_MULV;
			PC_MUL + 5'd2, PC_ENC + 5'd2, PC_DEC + 5'd2, PC_PMUL + 5'd2, PC_PSQR + 5'd2:
				c.dp = DP_MULQ;
			PC_MUL + 5'd3, PC_ENC + 5'd3, PC_DEC + 5'd3, PC_PMUL + 5'd3, PC_PSQR + 5'd3:
				c.dp = DP_ADD;
			PC_MUL + 5'd4, PC_ENC + 5'd4, PC_DEC + 5'd4: begin
				c.dp  = DP_FIN;
				c.dst = D_RES;
				c.jmp = J_DONE;
			end
			PC_PMUL + 5'd4: begin
				c.dp  = DP_FIN;
				c.dst = D_ACC;
			end
			PC_PSQR + 5'd4: begin
				c.dp  = DP_FIN;
				c.dst = D_SQ;
				c.jmp = J_LOOP;
				c.tgt = PC_POUT;
			end
			PC_POUT: begin
				c.dp  = DP_OUTACC;
				c.jmp = J_DONE;
			end
			default: begin
				c.jmp = J_GOTO;
				c.tgt = PC_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

[sv/mma_req_if.sv]
// Request channel of the Montgomery arithmetic unit: valid/ready plus request fields.
// Depends on mma_pkg for the field widths.

interface mma_req_if;
	logic                       valid;
	logic                       ready;
	logic [mma_pkg::OP_W-1:0]   operation;
	logic [mma_pkg::VAL_W-1:0]  operand_a;
	logic [mma_pkg::VAL_W-1:0]  operand_b;
	logic [mma_pkg::EXP_W-1:0]  exponent;

	modport source (output valid, operation, operand_a, operand_b, exponent, input ready);
	modport sink   (input valid, operation, operand_a, operand_b, exponent, output ready);
endinterface

[sv/mma_rsp_if.sv]
// Response channel of the Montgomery arithmetic unit: valid/ready plus the result.
// Depends on mma_pkg for the field width.

interface mma_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [mma_pkg::VAL_W-1:0] result;

	modport source (output valid, result, input ready);
	modport sink   (input valid, result, output ready);
endinterface

[sv/montgomery_modular_arith_unit.sv]
// Montgomery arithmetic unit (R = 2^32): microcoded sequencer over one shared multiplier.
// Depends on mma_pkg, mma_req_if and mma_rsp_if.
//
//  channel    dir  handshake        payload
//  req        in   valid / ready    operation, operand_a, operand_b, exponent
//  rsp        out  valid / ready    result
//  cfg        in   cfg_we           cfg_index, cfg_data
//
// Power runs one product per exponent bit and one more per set bit;
// the next request is taken in the cycle after the result is loaded.
// Each Montgomery product is three passes through the single 32x32 multiplier
// plus an add step and a subtract step, sequenced by the microprogram ROM.
// Reset returns the sequencer to idle and loads the register reset values.
// A new request is taken once the sequencer is idle, even while a result waits;
// the final step holds while an earlier result is still not taken.

module montgomery_modular_arith_unit #(
	parameter int EXP_BITS = mma_pkg::EXP_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mma_req_if.sink                        req,
	mma_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [mma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mma_pkg::MOD_W-1:0]      cfg_data
);

	localparam int CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(EXP_BITS - 1);

	localparam int VW = mma_pkg::VAL_W;
	localparam int MW = mma_pkg::MOD_W;
	localparam int PW = mma_pkg::PROD_W;

	// Configuration registers
	logic [MW-1:0] mod_q;
	logic [MW-1:0] ninv_q;
	logic [VW-1:0] r2_q;
	logic [VW-1:0] one_q;

	// Sequencer
	logic [mma_pkg::PC_W-1:0] pc_q, pc_d;
	mma_pkg::ctrl_word_t      ctrl;
	logic [CNT_W-1:0]         cnt_q;
	logic                     rsp_valid_q;
	logic                     accept;
	logic                     stall;
	logic                     cnt_last;

	// Datapath
	mma_pkg::op_t          op_q;
	logic [VW-1:0]         a_q, b_q, acc_q, sq_q, res_q;
	logic [EXP_BITS-1:0]   exp_q, exp_nxt;
	logic [2*VW-1:0]       p_q;
	logic [MW-1:0]         v_q;
	logic [PW-1:0]         w_q;
	logic [MW:0]           r_q;
	logic [MW-1:0]         mul_x, mul_y;
	logic [PW-1:0]         prod;
	logic [PW:0]           sum;
	logic [MW:0]           r_sub;
	logic [VW-1:0]         fin_val;

	assign ctrl     = mma_pkg::ucode(pc_q);
	assign req.ready = (pc_q == mma_pkg::PC_IDLE);
	assign accept   = req.valid && req.ready;
	assign stall    = (ctrl.jmp == mma_pkg::J_DONE) && rsp_valid_q && !rsp.ready;
	assign cnt_last = (cnt_q == CNT_LAST);
	assign exp_nxt  = exp_q >> 1;

	assign rsp.valid  = rsp_valid_q;
	assign rsp.result = res_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= MW'(1);
			ninv_q <= '0;
			r2_q   <= '0;
			one_q  <= '0;
		end else if (cfg_we) begin
			case (mma_pkg::cfg_idx_t'(cfg_index))
				mma_pkg::CFG_MODULUS: mod_q  <= cfg_data;
				mma_pkg::CFG_NEG_INV: ninv_q <= cfg_data;
				mma_pkg::CFG_R2:      r2_q   <= cfg_data[VW-1:0];
				mma_pkg::CFG_ONE:     one_q  <= cfg_data[VW-1:0];
				default: ;
			endcase
		end
	end

	// Select multiplier operands for the current step
	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (ctrl.dp)
			mma_pkg::DP_MULXY: begin
				case (ctrl.xs)
					mma_pkg::X_A:   mul_x = {1'b0, a_q};
					mma_pkg::X_ACC: mul_x = {1'b0, acc_q};
					mma_pkg::X_SQ:  mul_x = {1'b0, sq_q};
					default:        mul_x = '0;
				endcase
				case (ctrl.ys)
					mma_pkg::Y_B:   mul_y = {1'b0, b_q};
					mma_pkg::Y_R2:  mul_y = {1'b0, r2_q};
					mma_pkg::Y_ONE: mul_y = MW'(1);
					mma_pkg::Y_SQ:  mul_y = {1'b0, sq_q};
					default:        mul_y = '0;
				endcase
			end
			mma_pkg::DP_MULV: begin
				mul_x = p_q[MW-1:0];
				mul_y = ninv_q;
			end
			mma_pkg::DP_MULQ: begin
				mul_x = v_q;
				mul_y = mod_q;
			end
			default: ;
		endcase
	end

	// Shared multiplier, add-and-shift and final conditional subtraction
	assign prod    = PW'(mul_x) * PW'(mul_y);
	assign sum     = {3'b000, p_q} + {1'b0, w_q};
	assign r_sub   = r_q - {1'b0, mod_q};
	assign fin_val = (r_q >= {1'b0, mod_q}) ? r_sub[VW-1:0] : r_q[VW-1:0];

	// Next step of the microprogram
	always_comb begin
		pc_d = pc_q;
		case (ctrl.jmp)
			mma_pkg::J_WAIT: pc_d = accept ? mma_pkg::PC_DISP : mma_pkg::PC_IDLE;
			mma_pkg::J_NEXT: pc_d = pc_q + mma_pkg::PC_W'(1);
			mma_pkg::J_GOTO: pc_d = ctrl.tgt;
			mma_pkg::J_OP: begin
				case (op_q)
					mma_pkg::OP_MUL: pc_d = mma_pkg::PC_MUL;
					mma_pkg::OP_ENC: pc_d = mma_pkg::PC_ENC;
					mma_pkg::OP_DEC: pc_d = mma_pkg::PC_DEC;
					mma_pkg::OP_POW: pc_d = mma_pkg::PC_POW;
					default:         pc_d = mma_pkg::PC_IDLE;
				endcase
			end
			mma_pkg::J_BIT:  pc_d = exp_q[0] ? pc_q + mma_pkg::PC_W'(1) : ctrl.tgt;
			mma_pkg::J_LOOP: begin
				if (cnt_last)
					pc_d = ctrl.tgt;
				else
					pc_d = exp_nxt[0] ? mma_pkg::PC_PMUL : mma_pkg::PC_PSQR;
			end
			mma_pkg::J_DONE: pc_d = stall ? pc_q : mma_pkg::PC_IDLE;
			default:         pc_d = mma_pkg::PC_IDLE;
		endcase
	end

	// Advance sequencer, round counter and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= mma_pkg::PC_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (accept)
				cnt_q <= '0;
			else if (ctrl.jmp == mma_pkg::J_LOOP && !cnt_last)
				cnt_q <= cnt_q + CNT_W'(1);
			if (ctrl.jmp == mma_pkg::J_DONE && !stall)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// Load request and run the datapath step
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= mma_pkg::op_t'(req.operation);
			a_q   <= req.operand_a;
			b_q   <= req.operand_b;
			exp_q <= req.exponent[EXP_BITS-1:0];
			acc_q <= one_q;
			sq_q  <= req.operand_a;
		end
		if (ctrl.jmp == mma_pkg::J_LOOP)
			exp_q <= exp_nxt;
		if (!stall) begin
			case (ctrl.dp)
				mma_pkg::DP_MULXY:  p_q <= prod[2*VW-1:0];
				mma_pkg::DP_MULV:   v_q <= prod[MW-1:0];
				mma_pkg::DP_MULQ:   w_q <= prod;
				mma_pkg::DP_ADD:    r_q <= sum[PW:MW];
				mma_pkg::DP_FIN: begin
					case (ctrl.dst)
						mma_pkg::D_ACC: acc_q <= fin_val;
						mma_pkg::D_SQ:  sq_q  <= fin_val;
						mma_pkg::D_RES: res_q <= fin_val;
						default: ;
					endcase
				end
				mma_pkg::DP_OUTACC: res_q <= acc_q;
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (pc_q == mma_pkg::PC_DISP))
		else $error("accepted request did not move to dispatch");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("round counter beyond exponent length");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (pc_q == $past(pc_q)) && $stable(res_q))
		else $error("final step moved while result still pending");

	a_pow_init: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (acc_q == $past(one_q)) && (sq_q == $past(req.operand_a)))
		else $error("power registers not initialised on acceptance");
`endif

endmodule

[verif/mma_result_checker.sv]
// Result checker for the Montgomery arithmetic unit: tracks register writes,
// predicts each result and compares it on the response channel.
// Depends on mma_pkg, mma_req_if and mma_rsp_if.

module mma_result_checker #(
	parameter int EXP_BITS = mma_pkg::EXP_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mma_req_if                             req,
	mma_rsp_if                             rsp,
	input  logic                           cfg_we,
	input  logic [mma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mma_pkg::MOD_W-1:0]      cfg_data,
	output int                             mismatches,
	output int                             pending,
	output int                             checked
);
	import mma_pkg::*;

	typedef struct {
		op_t              op;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
		logic [EXP_W-1:0] e;
		logic [VAL_W-1:0] value;
	} mont_due_t;

	// Local copy of the register file
	logic [MOD_W-1:0] q_mod;
	logic [MOD_W-1:0] q_ninv;
	logic [VAL_W-1:0] r2_mod;
	logic [VAL_W-1:0] one_mf;

	mont_due_t mont_results_due[$];
	int        err_count;
	int        cmp_count;

	// Montgomery reduction with the carry of the sum kept, cut to 31 bits
	function automatic logic [VAL_W-1:0] redc(logic [63:0] m);
		logic [31:0] v;
		logic [63:0] vq;
		logic [64:0] sum;
		logic [32:0] r;
		v   = m[31:0] * q_ninv;
		vq  = {32'd0, v} * {32'd0, q_mod};
		sum = {1'b0, m} + {1'b0, vq};
		r   = sum[64:32];
		if (r >= {1'b0, q_mod})
			r = r - {1'b0, q_mod};
		return r[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] mont_product(logic [VAL_W-1:0] x, logic [VAL_W-1:0] y);
		return redc({33'd0, x} * {33'd0, y});
	endfunction

	// Square-and-multiply over the low EXP_BITS exponent bits
	function automatic logic [VAL_W-1:0] mont_power(logic [VAL_W-1:0] base, logic [EXP_W-1:0] e);
		logic [VAL_W-1:0] acc;
		logic [VAL_W-1:0] sq;
		acc = one_mf;
		sq  = base;
		for (int i = 0; i < EXP_BITS; i++) begin
			if (e[i])
				acc = mont_product(acc, sq);
			sq = mont_product(sq, sq);
		end
		return acc;
	endfunction

	function automatic logic [VAL_W-1:0] mont_op_result(op_t op, logic [VAL_W-1:0] a,
			logic [VAL_W-1:0] b, logic [EXP_W-1:0] e);
		case (op)
			OP_MUL:  return mont_product(a, b);
			OP_ENC:  return mont_product(a, r2_mod);
			OP_DEC:  return redc({33'd0, a});
			default: return mont_power(a, e);
		endcase
	endfunction

	// Follow register writes, queue predictions, compare responses in order
	always @(posedge clk or negedge arst_n) begin
		mont_due_t due;
		if (!arst_n) begin
			q_mod     = 32'd1;
			q_ninv    = '0;
			r2_mod    = '0;
			one_mf    = '0;
			err_count = 0;
			cmp_count = 0;
			mont_results_due.delete();
			pending    <= 0;
			mismatches <= 0;
			checked    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODULUS: q_mod  = cfg_data;
					CFG_NEG_INV: q_ninv = cfg_data;
					CFG_R2:      r2_mod = cfg_data[VAL_W-1:0];
					CFG_ONE:     one_mf = cfg_data[VAL_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				due.op    = op_t'(req.operation);
				due.a     = req.operand_a;
				due.b     = req.operand_b;
				due.e     = req.exponent;
				due.value = mont_op_result(due.op, due.a, due.b, due.e);
				mont_results_due.push_back(due);
			end
			if (rsp.valid && rsp.ready) begin
				if (mont_results_due.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result, expected none, actual %h",
						$time, rsp.result);
				end else begin
					due = mont_results_due.pop_front();
					cmp_count++;
					if (rsp.result !== due.value) begin
						err_count++;
						$display("%0t: result mismatch (%s a=%h b=%h e=%h), expected %h, actual %h",
							$time, due.op.name(), due.a, due.b, due.e, due.value, rsp.result);
					end
				end
			end
			pending    <= mont_results_due.size();
			mismatches <= err_count;
			checked    <= cmp_count;
		end
	end

endmodule

[verif/montgomery_modular_arith_unit_tb.sv]
// Testbench top for the Montgomery arithmetic unit: clock, reset, register
// writes, request stimulus and response back-pressure; verdict from the checker.
// Depends on mma_pkg, mma_req_if, mma_rsp_if, mma_result_checker and the RTL.

module montgomery_modular_arith_unit_tb;
	import mma_pkg::*;

	localparam int EXP_BITS   = EXP_BITS_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int N_PHASES   = 10;
	localparam int PHASE_ITEMS = 105;

	typedef struct {
		logic [MOD_W-1:0] q;
		logic [MOD_W-1:0] ninv;
		logic [MOD_W-1:0] r2;
		logic [MOD_W-1:0] one;
	} reg_set_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MOD_W-1:0]     cfg_data;

	int mismatches;
	int pending;
	int checked;

	mma_req_if req_ch ();
	mma_rsp_if rsp_ch ();

	montgomery_modular_arith_unit #(.EXP_BITS(EXP_BITS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mma_result_checker #(.EXP_BITS(EXP_BITS)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Response back-pressure: rotate a stall pattern, reload it when its age count runs out
	logic [15:0] ready_pat;
	int          ready_age = 0;
	int          ready_pick;

	always @(posedge clk) begin
		if (ready_age == 0) begin
			ready_age  = 48;
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 30)
				ready_pat = '1;
			else if (ready_pick < 75)
				ready_pat = 16'($urandom);
			else
				ready_pat = 16'($urandom & $urandom & $urandom);
		end else begin
			ready_pat = {ready_pat[14:0], ready_pat[15]};
			ready_age--;
		end
		rsp_ch.ready <= ready_pat[0];
	end

	// Watchdog: give up after a long stretch with no transaction on either channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transaction for %0d cycles, %0d results outstanding",
			$time, IDLE_LIMIT, pending);
		$display("Simulation FAILED");
		$finish;
	end

	int burst_left;
	int sent_by_op[4];
	int settings_used;

	// Valid register set for an odd modulus: -q^-1 by Newton steps, R^2 and R mod q
	function automatic reg_set_t proper_regs(logic [MOD_W-1:0] q);
		reg_set_t    s;
		logic [31:0] inv;
		inv = q;
		repeat (5) inv = inv * (32'd2 - q * inv);
		s.q    = q;
		s.ninv = -inv;
		s.r2   = MOD_W'((65'd1 << 64) % {33'd0, q});
		s.one  = MOD_W'((65'd1 << 32) % {33'd0, q});
		return s;
	endfunction

	function automatic reg_set_t junk_regs(logic [MOD_W-1:0] q);
		reg_set_t s;
		s.q    = q;
		s.ninv = $urandom;
		s.r2   = $urandom;
		s.one  = $urandom;
		return s;
	endfunction

	// Mostly below the modulus, with the edges and full-width values mixed in
	function automatic logic [VAL_W-1:0] pick_operand(logic [MOD_W-1:0] q);
		int sel;
		sel = $urandom_range(0, 15);
		if (q == 0 || q > 32'h8000_0000 || sel == 0)
			return VAL_W'($urandom);
		if (sel == 1)
			return '0;
		if (sel == 2)
			return VAL_W'(q - 32'd1);
		return VAL_W'($urandom % q);
	endfunction

	function automatic logic [EXP_W-1:0] pick_exponent();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		if (sel == 2)
			return EXP_W'($urandom_range(1, 15));
		if (sel == 3)
			return {1'b1, 63'd0} | EXP_W'($urandom_range(0, 1));
		return {$urandom, $urandom};
	endfunction

	// Keep valid up through a burst, drop it for a random gap in between
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 6);
			gap = $urandom_range(1, 10);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Present one request and hold it until the transaction completes
	task automatic issue(op_t op, logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
			logic [EXP_W-1:0] e);
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		req_ch.exponent  <= e;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sent_by_op[op]++;
		pace();
	endtask

	// Drain every outstanding result, then let the sequencer settle
	task automatic wait_quiet();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apply_regs(reg_set_t s);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MODULUS;
		cfg_data  <= s.q;
		@(posedge clk);
		cfg_index <= CFG_NEG_INV;
		cfg_data  <= s.ninv;
		@(posedge clk);
		cfg_index <= CFG_R2;
		cfg_data  <= s.r2;
		@(posedge clk);
		cfg_index <= CFG_ONE;
		cfg_data  <= s.one;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		reg_set_t         regs;
		logic [MOD_W-1:0] q;
		logic [VAL_W-1:0] ones;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_MODULUS;
		cfg_data         = '0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_MUL;
		req_ch.operand_a = '0;
		req_ch.operand_b = '0;
		req_ch.exponent  = '0;
		burst_left       = 0;
		settings_used    = 1;
		ones             = '1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset values
		issue(OP_MUL, ones, ones, '0);
		issue(OP_ENC, 31'd5, '0, '0);
		issue(OP_DEC, ones, '0, '0);
		issue(OP_POW, ones, '0, '1);

		// Largest proper modulus: operand edges, every operation, exponent edges
		wait_quiet();
		regs = proper_regs(32'h7FFF_FFFF);
		apply_regs(regs);
		issue(OP_MUL, '0, '0, '0);
		issue(OP_MUL, VAL_W'(regs.q - 32'd1), VAL_W'(regs.q - 32'd1), '0);
		issue(OP_MUL, ones, ones, '0);
		issue(OP_ENC, '0, ones, '0);
		issue(OP_ENC, VAL_W'(regs.q - 32'd1), '0, '0);
		issue(OP_DEC, '0, '0, '0);
		issue(OP_DEC, 31'd1, '0, '0);
		issue(OP_DEC, VAL_W'(regs.q - 32'd1), '0, '0);
		issue(OP_POW, 31'h2345_6789, '0, '0);
		issue(OP_POW, 31'h2345_6789, '0, 64'd1);
		issue(OP_POW, 31'h2345_6789, ones, '1);
		issue(OP_POW, 31'h2345_6789, '0, {1'b1, 63'd0});
		issue(OP_POW, '0, '0, 64'hDEAD_BEEF_0123_4567);

		// Moduli of 2^31 and above, even and zero, with unrelated register contents
		wait_quiet();
		apply_regs(junk_regs(32'h8000_0000));
		issue(OP_MUL, ones, ones, '0);
		issue(OP_POW, ones, '0, '1);
		wait_quiet();
		apply_regs(junk_regs('0));
		issue(OP_DEC, ones, '0, '0);
		issue(OP_MUL, ones, 31'h5555_5555, '0);
		wait_quiet();
		apply_regs(junk_regs('1));
		issue(OP_MUL, ones, ones, '0);
		issue(OP_ENC, ones, '0, '0);

		// Random phases, each under its own register setting
		for (int p = 0; p < N_PHASES; p++) begin
			wait_quiet();
			case (p)
				0: regs = proper_regs(32'd3);
				1: regs = proper_regs(32'h7FFF_FFFF);
				2: regs = proper_regs(($urandom | 32'h4000_0001) & 32'h7FFF_FFFF);
				3: regs = proper_regs($urandom_range(1, 255) | 1);
				4: regs = proper_regs(($urandom & 32'h7FFF_FFFF) | 1);
				5: regs = proper_regs(32'd1);
				6: regs = junk_regs(32'h8000_0000);
				7: regs = junk_regs('0);
				8: regs = junk_regs($urandom | 32'h8000_0001);
				default: regs = junk_regs(($urandom & 32'h7FFF_FFFE) | 32'd2);
			endcase
			apply_regs(regs);
			q = regs.q;
			repeat (PHASE_ITEMS)
				issue(op_t'($urandom_range(0, 3)), pick_operand(q), pick_operand(q),
					pick_exponent());
		end

		wait_quiet();
		repeat (16) @(posedge clk);
		$display("Covered %0d multiply, %0d encode, %0d decode, %0d power requests under %0d register settings",
			sent_by_op[OP_MUL], sent_by_op[OP_ENC], sent_by_op[OP_DEC], sent_by_op[OP_POW],
			settings_used);
		$display("%0d results compared, %0d mismatches", checked, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
sv/mma_pkg.sv
sv/mma_req_if.sv
sv/mma_rsp_if.sv
sv/montgomery_modular_arith_unit.sv
verif/mma_result_checker.sv
verif/montgomery_modular_arith_unit_tb.sv
